>>> rtl/rna_pkg.sv
// ----------------------------------------------------------------------------
// rna_pkg
// Shared operation codes, command and status types for the rational number ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package rna_pkg;

  localparam int unsigned FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_NORM = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INC  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEC  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_LT   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_EQ   = 3'd5;

  // Source of the fraction handed to the reduction unit
  typedef enum logic [1:0] {
    RED_SRC_A,
    RED_SRC_B,
    RED_SRC_SUM
  } red_src_e;

  // Multiplier operand pair and product destination
  typedef enum logic [2:0] {
    MUL_T1,
    MUL_T2,
    MUL_DD,
    MUL_LT1,
    MUL_LT2
  } mul_op_e;

  // Kind of result written to the output registers
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_RED,
    EMIT_INC,
    EMIT_LT,
    EMIT_EQ,
    EMIT_ERR,
    EMIT_ZERO
  } emit_e;

  typedef struct packed {
    logic     load;
    logic     red_start;
    red_src_e red_src;
    logic     mul_en;
    mul_op_e  mul_op;
    logic     save_a;
    logic     save_b;
    emit_e    emit;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              den_a_zero;
    logic              den_b_zero;
    logic              red_done;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/rna_reduce.sv
// ----------------------------------------------------------------------------
// rna_reduce
// Fraction reduction unit: strips common factors of two, finds the odd part of
// the GCD with a binary GCD loop, then divides numerator and denominator by it
// with two restoring dividers that run side by side, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_reduce #(
  parameter int unsigned MAG_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 neg_i,
  input  wire logic [MAG_WIDTH-1:0] nm_i,
  input  wire logic [MAG_WIDTH-1:0] dm_i,
  output logic                      done_o,
  output logic                      neg_o,
  output logic [MAG_WIDTH-1:0]      nm_o,
  output logic [MAG_WIDTH-1:0]      dm_o
);

  localparam int unsigned CNT_W = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;

  typedef enum logic [1:0] {
    R_IDLE,
    R_STRIP,
    R_GCD,
    R_DIV
  } phase_e;

  phase_e phase_q, phase_d;
  logic   done_q, done_d;

  logic [MAG_WIDTH-1:0] x_q, y_q, n_q, d_q, rn_q, rd_q, nm_q, dm_q;
  logic                 neg_q, oneg_q;
  logic [CNT_W-1:0]     cnt_q;

  logic                 x_eq_y, x_gt_y, x_is_one, strip_done;
  logic [MAG_WIDTH-1:0] x_minus_y, y_minus_x;
  logic [MAG_WIDTH:0]   rn_ext, rd_ext, rn_sub, rd_sub, dv_ext;
  logic                 qn_bit, qd_bit;

  assign x_eq_y     = (x_q == y_q);
  assign x_gt_y     = (x_q > y_q);
  assign x_is_one   = (x_q == MAG_WIDTH'(1));
  assign strip_done = x_q[0] | y_q[0];
  assign x_minus_y  = x_q - y_q;
  assign y_minus_x  = y_q - x_q;

  // The GCD stays in x during division
  assign dv_ext = {1'b0, x_q};
  assign rn_ext = {rn_q, n_q[MAG_WIDTH-1]};
  assign rd_ext = {rd_q, d_q[MAG_WIDTH-1]};
  assign rn_sub = rn_ext - dv_ext;
  assign rd_sub = rd_ext - dv_ext;
  assign qn_bit = (rn_ext >= dv_ext);
  assign qd_bit = (rd_ext >= dv_ext);

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    case (phase_q)
      R_IDLE: begin
        if (start_i) begin
          if (nm_i == '0) begin
            done_d = 1'b1;
          end else begin
            phase_d = R_STRIP;
          end
        end
      end
      R_STRIP: begin
        if (strip_done) begin
          phase_d = R_GCD;
        end
      end
      R_GCD: begin
        if (x_eq_y) begin
          if (x_is_one) begin
            done_d  = 1'b1;
            phase_d = R_IDLE;
          end else begin
            phase_d = R_DIV;
          end
        end
      end
      R_DIV: begin
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = R_IDLE;
        end
      end
      default: phase_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      R_IDLE: begin
        if (start_i) begin
          x_q   <= nm_i;
          y_q   <= dm_i;
          n_q   <= nm_i;
          d_q   <= dm_i;
          neg_q <= neg_i;
          if (nm_i == '0) begin
            nm_q   <= '0;
            dm_q   <= MAG_WIDTH'(1);
            oneg_q <= 1'b0;
          end
        end
      end
      R_STRIP: begin
        // drop a common factor of two from both pairs
        if (!strip_done) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          n_q <= n_q >> 1;
          d_q <= d_q >> 1;
        end
      end
      R_GCD: begin
        if (x_eq_y) begin
          rn_q  <= '0;
          rd_q  <= '0;
          cnt_q <= CNT_W'(MAG_WIDTH - 1);
          if (x_is_one) begin
            nm_q   <= n_q;
            dm_q   <= d_q;
            oneg_q <= neg_q;
          end
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_gt_y) begin
          x_q <= x_minus_y >> 1;
        end else begin
          y_q <= y_minus_x >> 1;
        end
      end
      R_DIV: begin
        // shift dividend bits out the top, quotient bits in the bottom
        rn_q  <= qn_bit ? rn_sub[MAG_WIDTH-1:0] : rn_ext[MAG_WIDTH-1:0];
        rd_q  <= qd_bit ? rd_sub[MAG_WIDTH-1:0] : rd_ext[MAG_WIDTH-1:0];
        n_q   <= {n_q[MAG_WIDTH-2:0], qn_bit};
        d_q   <= {d_q[MAG_WIDTH-2:0], qd_bit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          nm_q   <= {n_q[MAG_WIDTH-2:0], qn_bit};
          dm_q   <= {d_q[MAG_WIDTH-2:0], qd_bit};
          oneg_q <= neg_q;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign neg_o  = oneg_q;
  assign nm_o   = nm_q;
  assign dm_o   = dm_q;

endmodule

`default_nettype wire

>>> rtl/rna_dp.sv
// ----------------------------------------------------------------------------
// rna_dp
// Datapath: operand registers, shared multiplier with product registers,
// sign-magnitude adder, reduction unit, saved reduced operands and the
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_dp #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rna_pkg::cmd_t                       cmd_i,
  output rna_pkg::stat_t                           stat_o,
  input  wire logic [rna_pkg::FUNC_W-1:0]          func_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]     num_a_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]     den_a_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]     num_b_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]     den_b_i,
  output logic signed [2*OPERAND_WIDTH:0]          res_num_o,
  output logic [2*OPERAND_WIDTH-2:0]               res_den_o,
  output logic                                     cmp_true_o,
  output logic                                     status_o,
  output logic                                     done_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned MW = 2 * W;
  localparam int unsigned SW = W + 1;
  localparam int unsigned PW = 2 * SW;
  localparam int unsigned NW = 2 * W + 1;
  localparam int unsigned DW = 2 * W - 1;
  localparam int unsigned IW = W + 2;

  logic [rna_pkg::FUNC_W-1:0] func_q;
  logic signed [W-1:0]        na_q, da_q, nb_q, db_q;

  logic                       a_neg_q, b_neg_q;
  logic [W-1:0]               a_nm_q, a_dm_q, b_nm_q, b_dm_q;
  logic signed [PW-1:0]       p1_q, p2_q, p3_q;

  logic signed [NW-1:0]       res_num_q;
  logic [DW-1:0]              res_den_q;
  logic                       cmp_q, status_q, done_q;

  // operand magnitudes
  logic signed [SW-1:0] na_x, da_x, nb_x, db_x;
  logic [SW-1:0]        na_mag, da_mag, nb_mag, db_mag;

  assign na_x   = $signed({na_q[W-1], na_q});
  assign da_x   = $signed({da_q[W-1], da_q});
  assign nb_x   = $signed({nb_q[W-1], nb_q});
  assign db_x   = $signed({db_q[W-1], db_q});
  assign na_mag = na_x[SW-1] ? -na_x : na_x;
  assign da_mag = da_x[SW-1] ? -da_x : da_x;
  assign nb_mag = nb_x[SW-1] ? -nb_x : nb_x;
  assign db_mag = db_x[SW-1] ? -db_x : db_x;

  // reduced operands in signed form
  logic signed [SW-1:0] an_x, ad_x, bn_x, bd_x;

  assign an_x = a_neg_q ? -$signed({1'b0, a_nm_q}) : $signed({1'b0, a_nm_q});
  assign bn_x = b_neg_q ? -$signed({1'b0, b_nm_q}) : $signed({1'b0, b_nm_q});
  assign ad_x = $signed({1'b0, a_dm_q});
  assign bd_x = $signed({1'b0, b_dm_q});

  // shared multiplier
  logic signed [SW-1:0] mul_x, mul_y;
  logic signed [PW-1:0] mul_p;

  always_comb begin
    case (cmd_i.mul_op)
      rna_pkg::MUL_T1: begin
        mul_x = na_x;
        mul_y = db_x;
      end
      rna_pkg::MUL_T2: begin
        mul_x = nb_x;
        mul_y = da_x;
      end
      rna_pkg::MUL_DD: begin
        mul_x = da_x;
        mul_y = db_x;
      end
      rna_pkg::MUL_LT1: begin
        mul_x = an_x;
        mul_y = bd_x;
      end
      rna_pkg::MUL_LT2: begin
        mul_x = ad_x;
        mul_y = bn_x;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_op)
        rna_pkg::MUL_T1, rna_pkg::MUL_LT1: p1_q <= mul_p;
        rna_pkg::MUL_T2, rna_pkg::MUL_LT2: p2_q <= mul_p;
        rna_pkg::MUL_DD:                   p3_q <= mul_p;
        default: ;
      endcase
    end
  end

  // sign-magnitude sum of the cross products
  logic [PW-1:0] m1_w, m2_w, m3_w;
  logic [MW-1:0] m1, m2, sum_mag;
  logic          s1, s2, s3, sum_neg;

  assign s1   = p1_q[PW-1];
  assign s2   = p2_q[PW-1];
  assign s3   = p3_q[PW-1];
  assign m1_w = s1 ? -p1_q : p1_q;
  assign m2_w = s2 ? -p2_q : p2_q;
  assign m3_w = s3 ? -p3_q : p3_q;
  assign m1   = m1_w[MW-1:0];
  assign m2   = m2_w[MW-1:0];

  always_comb begin
    if (s1 == s2) begin
      sum_mag = m1 + m2;
      sum_neg = s1;
    end else if (m1 >= m2) begin
      sum_mag = m1 - m2;
      sum_neg = s1;
    end else begin
      sum_mag = m2 - m1;
      sum_neg = s2;
    end
  end

  // reduction unit
  logic          red_in_neg, red_neg, red_done;
  logic [MW-1:0] red_in_nm, red_in_dm, red_nm, red_dm;

  always_comb begin
    case (cmd_i.red_src)
      rna_pkg::RED_SRC_A: begin
        red_in_neg = na_q[W-1] ^ da_q[W-1];
        red_in_nm  = MW'(na_mag);
        red_in_dm  = MW'(da_mag);
      end
      rna_pkg::RED_SRC_B: begin
        red_in_neg = nb_q[W-1] ^ db_q[W-1];
        red_in_nm  = MW'(nb_mag);
        red_in_dm  = MW'(db_mag);
      end
      rna_pkg::RED_SRC_SUM: begin
        red_in_neg = sum_neg ^ s3;
        red_in_nm  = sum_mag;
        red_in_dm  = m3_w[MW-1:0];
      end
      default: begin
        red_in_neg = 1'b0;
        red_in_nm  = '0;
        red_in_dm  = '0;
      end
    endcase
  end

  rna_reduce #(
    .MAG_WIDTH(MW)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.red_start),
    .neg_i  (red_in_neg),
    .nm_i   (red_in_nm),
    .dm_i   (red_in_dm),
    .done_o (red_done),
    .neg_o  (red_neg),
    .nm_o   (red_nm),
    .dm_o   (red_dm)
  );

  // operand and reduced-operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      na_q   <= num_a_i;
      da_q   <= den_a_i;
      nb_q   <= num_b_i;
      db_q   <= den_b_i;
    end
    if (cmd_i.save_a) begin
      a_neg_q <= red_neg;
      a_nm_q  <= red_nm[W-1:0];
      a_dm_q  <= red_dm[W-1:0];
    end
    if (cmd_i.save_b) begin
      b_neg_q <= red_neg;
      b_nm_q  <= red_nm[W-1:0];
      b_dm_q  <= red_dm[W-1:0];
    end
  end

  // results
  logic signed [NW-1:0] red_num_x;
  logic signed [IW-1:0] inc_n, inc_d, inc_r;
  logic                 a_eq_b, a_lt_b;

  assign red_num_x = red_neg ? -$signed({1'b0, red_nm}) : $signed({1'b0, red_nm});
  assign inc_n     = $signed({an_x[SW-1], an_x});
  assign inc_d     = $signed({2'b00, a_dm_q});
  assign inc_r     = (func_q == rna_pkg::FUNC_DEC) ? (inc_n - inc_d) : (inc_n + inc_d);
  assign a_eq_b    = (a_neg_q == b_neg_q) && (a_nm_q == b_nm_q) && (a_dm_q == b_dm_q);
  assign a_lt_b    = (p1_q < p2_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      rna_pkg::EMIT_RED: begin
        res_num_q <= red_num_x;
        res_den_q <= red_dm[DW-1:0];
        cmp_q     <= 1'b0;
        status_q  <= 1'b0;
      end
      rna_pkg::EMIT_INC: begin
        res_num_q <= NW'(inc_r);
        res_den_q <= DW'(a_dm_q);
        cmp_q     <= 1'b0;
        status_q  <= 1'b0;
      end
      rna_pkg::EMIT_LT: begin
        res_num_q <= '0;
        res_den_q <= '0;
        cmp_q     <= a_lt_b;
        status_q  <= 1'b0;
      end
      rna_pkg::EMIT_EQ: begin
        res_num_q <= '0;
        res_den_q <= '0;
        cmp_q     <= a_eq_b;
        status_q  <= 1'b0;
      end
      rna_pkg::EMIT_ERR: begin
        res_num_q <= '0;
        res_den_q <= '0;
        cmp_q     <= 1'b0;
        status_q  <= 1'b1;
      end
      rna_pkg::EMIT_ZERO: begin
        res_num_q <= '0;
        res_den_q <= '0;
        cmp_q     <= 1'b0;
        status_q  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.emit != rna_pkg::EMIT_NONE);
    end
  end

  assign stat_o.func       = func_q;
  assign stat_o.den_a_zero = (da_q == '0);
  assign stat_o.den_b_zero = (db_q == '0);
  assign stat_o.red_done   = red_done;

  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign cmp_true_o = cmp_q;
  assign status_o   = status_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

>>> rtl/rna_ctrl.sv
// ----------------------------------------------------------------------------
// rna_ctrl
// Sequencer: decodes the operation, checks denominators, and steps the
// datapath through multiplies, reductions and the final result write.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire rna_pkg::stat_t stat_i,
  output rna_pkg::cmd_t       cmd_o,
  output logic                busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED_A,
    S_INC,
    S_RED_B,
    S_EQ,
    S_LT1,
    S_LT2,
    S_LT,
    S_T2,
    S_DD,
    S_SUM,
    S_RED_S
  } state_e;

  state_e        state_q, state_d;
  logic          busy_q;
  logic          uses_b;
  rna_pkg::cmd_t cmd;

  assign uses_b = stat_i.func inside {rna_pkg::FUNC_ADD, rna_pkg::FUNC_LT, rna_pkg::FUNC_EQ};

  always_comb begin
    state_d       = state_q;
    cmd           = '0;
    cmd.red_src   = rna_pkg::RED_SRC_A;
    cmd.mul_op    = rna_pkg::MUL_T1;
    cmd.emit      = rna_pkg::EMIT_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.func > rna_pkg::FUNC_EQ) begin
          cmd.emit = rna_pkg::EMIT_ZERO;
          state_d  = S_IDLE;
        end else if (stat_i.den_a_zero || (uses_b && stat_i.den_b_zero)) begin
          cmd.emit = rna_pkg::EMIT_ERR;
          state_d  = S_IDLE;
        end else if (stat_i.func == rna_pkg::FUNC_ADD) begin
          cmd.mul_en = 1'b1;
          cmd.mul_op = rna_pkg::MUL_T1;
          state_d    = S_T2;
        end else begin
          cmd.red_start = 1'b1;
          cmd.red_src   = rna_pkg::RED_SRC_A;
          state_d       = S_RED_A;
        end
      end
      S_RED_A: begin
        if (stat_i.red_done) begin
          cmd.save_a = 1'b1;
          if (stat_i.func == rna_pkg::FUNC_NORM) begin
            cmd.emit = rna_pkg::EMIT_RED;
            state_d  = S_IDLE;
          end else if (stat_i.func == rna_pkg::FUNC_INC ||
                       stat_i.func == rna_pkg::FUNC_DEC) begin
            state_d = S_INC;
          end else begin
            cmd.red_start = 1'b1;
            cmd.red_src   = rna_pkg::RED_SRC_B;
            state_d       = S_RED_B;
          end
        end
      end
      S_INC: begin
        // A is already in lowest terms, so A +/- 1 needs no second reduction
        cmd.emit = rna_pkg::EMIT_INC;
        state_d  = S_IDLE;
      end
      S_RED_B: begin
        if (stat_i.red_done) begin
          cmd.save_b = 1'b1;
          state_d    = (stat_i.func == rna_pkg::FUNC_EQ) ? S_EQ : S_LT1;
        end
      end
      S_EQ: begin
        cmd.emit = rna_pkg::EMIT_EQ;
        state_d  = S_IDLE;
      end
      S_LT1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = rna_pkg::MUL_LT1;
        state_d    = S_LT2;
      end
      S_LT2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = rna_pkg::MUL_LT2;
        state_d    = S_LT;
      end
      S_LT: begin
        cmd.emit = rna_pkg::EMIT_LT;
        state_d  = S_IDLE;
      end
      S_T2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = rna_pkg::MUL_T2;
        state_d    = S_DD;
      end
      S_DD: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = rna_pkg::MUL_DD;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd.red_start = 1'b1;
        cmd.red_src   = rna_pkg::RED_SRC_SUM;
        state_d       = S_RED_S;
      end
      S_RED_S: begin
        if (stat_i.red_done) begin
          cmd.emit = rna_pkg::EMIT_RED;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = busy_q;

endmodule

`default_nettype wire

>>> rtl/rational_number_alu_core.sv
// ----------------------------------------------------------------------------
// rational_number_alu_core
// Fraction ALU: reduce, add, increment, decrement, less-than and equal on
// signed fractions, results reduced by their GCD with a positive denominator.
//
//   channel  | ports                                    | handshake
//   ---------+------------------------------------------+--------------------
//   command  | func_i num_a_i den_a_i num_b_i den_b_i   | start_i, busy_o
//   result   | res_num_o res_den_o cmp_true_o status_o  | done_o (one cycle)
//
// An item is taken when start_i is high and busy_o is low; busy_o stays high
// until its result is written. A reduction with a zero numerator runs neither
// the binary GCD loop nor the divider, and one whose odd GCD part is one skips
// the divider; compares run two reductions, errors and unused codes none.
// Reset clears the sequencer and the strobe; the result strobe is not held.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_number_alu_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [rna_pkg::FUNC_W-1:0]       func_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]  num_a_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]  den_a_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]  num_b_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]  den_b_i,
  output logic                                  done_o,
  output logic signed [2*OPERAND_WIDTH:0]       res_num_o,
  output logic [2*OPERAND_WIDTH-2:0]            res_den_o,
  output logic                                  cmp_true_o,
  output logic                                  status_o
);

  rna_pkg::cmd_t  cmd;
  rna_pkg::stat_t stat;

  rna_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  rna_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .func_i    (func_i),
    .num_a_i   (num_a_i),
    .den_a_i   (den_a_i),
    .num_b_i   (num_b_i),
    .den_b_i   (den_b_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .cmp_true_o(cmp_true_o),
    .status_o  (status_o),
    .done_o    (done_o)
  );

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe high in two consecutive cycles");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not raise busy");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (res_num_o == '0 && res_den_o == '0 && !cmp_true_o))
    else $error("error result carries nonzero fields");

endmodule

`default_nettype wire
